// ----- rtl/pcomp_pkg.sv -----
// pcomp_pkg: shared types, constants and modular multiply helpers for pressure compensation
`default_nettype none
package pcomp_pkg;

  // status codes of a result
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ZERO_DIV = 2'd1;
  localparam logic [1:0] ST_NON_POS = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TEMP    = 2'd0;
  localparam logic [1:0] CFG_PRESS_A = 2'd1;
  localparam logic [1:0] CFG_PRESS_B = 2'd2;
  localparam logic [1:0] CFG_PRESS_9 = 2'd3;

  // divider width and pipeline depth ahead of the output register
  localparam int DIV_BITS = 64;
  localparam int PRE_STAGES = 12;
  localparam int POST_STAGES = 5;
  localparam int NSTG = PRE_STAGES + DIV_BITS + 1 + POST_STAGES;

  // partial products of a 64 x 64 multiply kept modulo 2^64
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
  } pp_t;

  // three 32 x 32 partial products
  function automatic pp_t pp_mul(input logic [63:0] x, input logic [63:0] y);
    pp_t r;
    r.ll = x[31:0] * y[31:0];
    r.lh = x[31:0] * y[63:32];
    r.hl = x[63:32] * y[31:0];
    return r;
  endfunction

  // low 64 bits of the full product
  function automatic logic [63:0] pp_sum(input pp_t p);
    logic [31:0] mid;
    mid = p.lh + p.hl;
    return p.ll + {mid, 32'd0};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/pressure_temperature_compensation_unit.sv -----
// pressure_temperature_compensation_unit: pipelined barometric pressure and temperature compensation
`default_nettype none
// Takes one raw pressure and temperature pair per cycle unless stalled and gives the temperature in
// hundredths of a degree and the pressure in unsigned Q24.8 pascals with a status code.
// The datapath has 83 register stages: 12 stages of calibration math, a divider entry
// stage, a 64-stage radix-2 restoring divider (one quotient bit per stage), 5 stages of
// second-order correction and the output register. The whole pipe advances together; a
// one-entry skid buffer behind the output register holds a result the consumer stalls, and
// in_stall is raised only while that buffer is occupied. Coefficients are read directly
// from the configuration registers by every stage that uses them, so they are to be written
// only while no request is in flight.
module pressure_temperature_compensation_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [19:0] raw_pressure,
  input  wire logic [19:0] raw_temperature,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] temperature_centi,
  output logic [31:0]      pressure_q24_8,
  output logic [1:0]       status
);

  // configuration registers
  logic [47:0] temp_coeffs;
  logic [63:0] press_coeffs_a;
  logic [63:0] press_coeffs_b;
  logic [15:0] press_coeff_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coeffs      <= '0;
      press_coeffs_a   <= '0;
      press_coeffs_b   <= '0;
      press_coeff_nine <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        pcomp_pkg::CFG_TEMP:    temp_coeffs      <= cfg_data[47:0];
        pcomp_pkg::CFG_PRESS_A: press_coeffs_a   <= cfg_data;
        pcomp_pkg::CFG_PRESS_B: press_coeffs_b   <= cfg_data;
        pcomp_pkg::CFG_PRESS_9: press_coeff_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // coefficient slices
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = temp_coeffs[15:0];
  assign t2 = $signed(temp_coeffs[31:16]);
  assign t3 = $signed(temp_coeffs[47:32]);
  assign p1 = press_coeffs_a[15:0];
  assign p2 = $signed(press_coeffs_a[31:16]);
  assign p3 = $signed(press_coeffs_a[47:32]);
  assign p4 = $signed(press_coeffs_a[63:48]);
  assign p5 = $signed(press_coeffs_b[15:0]);
  assign p6 = $signed(press_coeffs_b[31:16]);
  assign p7 = $signed(press_coeffs_b[47:32]);
  assign p8 = $signed(press_coeffs_b[63:48]);
  assign p9 = $signed(press_coeff_nine);

  // pipeline control: everything moves unless the skid buffer is full
  logic en;
  logic accept;
  logic skid_v;
  logic o_v;
  logic vld [0:pcomp_pkg::NSTG-1];

  assign en       = !skid_v;
  assign in_stall = skid_v;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < pcomp_pkg::NSTG; k++) vld[k] <= 1'b0;
      o_v <= 1'b0;
    end else if (en) begin
      vld[0] <= accept;
      for (int k = 1; k < pcomp_pkg::NSTG; k++) vld[k] <= vld[k-1];
      o_v <= vld[pcomp_pkg::NSTG-1];
    end
  end

  // stage 1: first temperature products
  logic signed [17:0] tdiff;
  logic signed [16:0] dt;
  logic signed [33:0] s1_ta, s1_dd;
  logic [20:0]        s1_pd;
  assign tdiff = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign dt    = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ta <= tdiff * t2;
      s1_dd <= dt * dt;
      s1_pd <= 21'd1048576 - {1'b0, raw_pressure};
    end
  end

  // stage 2: quadratic-term product
  logic signed [22:0] s2_ta;
  logic signed [37:0] s2_tb;
  logic [20:0]        s2_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s2_ta <= $signed(s1_ta[33:11]);
      s2_tb <= $signed(s1_dd[33:12]) * t3;
      s2_pd <= s1_pd;
    end
  end

  // stage 3: fine temperature
  logic signed [24:0] s3_fine;
  logic [20:0]        s3_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s3_fine <= s2_ta + $signed(s2_tb[37:14]);
      s3_pd   <= s2_pd;
    end
  end

  // stage 4: temperature in centidegrees and pressure offset
  logic signed [27:0] c5;
  logic signed [19:0] ctmp;
  logic signed [15:0] centi;
  logic signed [25:0] s4_a;
  logic signed [15:0] s4_centi;
  logic [20:0]        s4_pd;
  assign c5   = s3_fine * 28'sd5 + 28'sd128;
  assign ctmp = $signed(c5[27:8]);
  always_comb begin
    if (ctmp > 20'sd32767) begin
      centi = 16'sh7fff;
    end else if (ctmp < -20'sd32768) begin
      centi = -16'sd32768;
    end else begin
      centi = ctmp[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_a     <= s3_fine - 26'sd128000;
      s4_centi <= centi;
      s4_pd    <= s3_pd;
    end
  end

  // stage 5: square and linear products of the offset
  logic signed [51:0] s5_aa;
  logic signed [41:0] s5_ap5, s5_ap2;
  logic signed [15:0] s5_centi;
  logic [20:0]        s5_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s5_aa    <= s4_a * s4_a;
      s5_ap5   <= s4_a * p5;
      s5_ap2   <= s4_a * p2;
      s5_centi <= s4_centi;
      s5_pd    <= s4_pd;
    end
  end

  // stage 6: partial products of the square terms
  pcomp_pkg::pp_t     s6_pp6, s6_pp3;
  logic signed [41:0] s6_ap5, s6_ap2;
  logic signed [15:0] s6_centi;
  logic [20:0]        s6_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s6_pp6   <= pcomp_pkg::pp_mul({{12{s5_aa[51]}}, s5_aa}, {{48{p6[15]}}, p6});
      s6_pp3   <= pcomp_pkg::pp_mul({{12{s5_aa[51]}}, s5_aa}, {{48{p3[15]}}, p3});
      s6_ap5   <= s5_ap5;
      s6_ap2   <= s5_ap2;
      s6_centi <= s5_centi;
      s6_pd    <= s5_pd;
    end
  end

  // stage 7: combine partial products
  logic [63:0]        s7_b6, s7_b3;
  logic signed [41:0] s7_ap5, s7_ap2;
  logic signed [15:0] s7_centi;
  logic [20:0]        s7_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s7_b6    <= pcomp_pkg::pp_sum(s6_pp6);
      s7_b3    <= pcomp_pkg::pp_sum(s6_pp3);
      s7_ap5   <= s6_ap5;
      s7_ap2   <= s6_ap2;
      s7_centi <= s6_centi;
      s7_pd    <= s6_pd;
    end
  end

  // stage 8: dividend offset and divisor factor
  logic [63:0]        s8_bsum, s8_x;
  logic signed [15:0] s8_centi;
  logic [20:0]        s8_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s8_bsum  <= s7_b6 + ({{22{s7_ap5[41]}}, s7_ap5} << 17) + ({{48{p4[15]}}, p4} << 35);
      s8_x     <= {{8{s7_b3[63]}}, s7_b3[63:8]} + ({{22{s7_ap2[41]}}, s7_ap2} << 12)
                  + (64'd1 << 47);
      s8_centi <= s7_centi;
      s8_pd    <= s7_pd;
    end
  end

  // stage 9: partial products of the divisor
  pcomp_pkg::pp_t     s9_pp1;
  logic [63:0]        s9_bsum;
  logic signed [15:0] s9_centi;
  logic [20:0]        s9_pd;
  always_ff @(posedge clk) begin
    if (en) begin
      s9_pp1   <= pcomp_pkg::pp_mul(s8_x, {48'd0, p1});
      s9_bsum  <= s8_bsum;
      s9_centi <= s8_centi;
      s9_pd    <= s8_pd;
    end
  end

  // stage 10: divisor
  logic [63:0]        prod1;
  logic [30:0]        s10_d;
  logic [63:0]        s10_bsum;
  logic signed [15:0] s10_centi;
  logic [20:0]        s10_pd;
  assign prod1 = pcomp_pkg::pp_sum(s9_pp1);
  always_ff @(posedge clk) begin
    if (en) begin
      s10_d     <= prod1[63:33];
      s10_bsum  <= s9_bsum;
      s10_centi <= s9_centi;
      s10_pd    <= s9_pd;
    end
  end

  // stage 11: dividend before scaling, zero divisor flag
  logic [63:0]        s11_n0;
  logic [30:0]        s11_d;
  logic               s11_zero;
  logic signed [15:0] s11_centi;
  always_ff @(posedge clk) begin
    if (en) begin
      s11_n0    <= ({43'd0, s10_pd} << 31) - s10_bsum;
      s11_d     <= s10_d;
      s11_zero  <= (s10_d == 31'd0);
      s11_centi <= s10_centi;
    end
  end

  // stage 12: scale by 3125 and divisor magnitude
  logic [63:0]        s12_n;
  logic [30:0]        s12_dm;
  logic               s12_dneg;
  logic               s12_zero;
  logic signed [15:0] s12_centi;
  always_ff @(posedge clk) begin
    if (en) begin
      s12_n     <= (s11_n0 << 11) + (s11_n0 << 10) + (s11_n0 << 5) + (s11_n0 << 4)
                   + (s11_n0 << 2) + s11_n0;
      s12_dm    <= s11_d[30] ? (31'd0 - s11_d) : s11_d;
      s12_dneg  <= s11_d[30];
      s12_zero  <= s11_zero;
      s12_centi <= s11_centi;
    end
  end

  // divider: entry stage then one quotient bit per stage
  logic [30:0]        dq_rem   [0:pcomp_pkg::DIV_BITS];
  logic [63:0]        dq_num   [0:pcomp_pkg::DIV_BITS];
  logic [30:0]        dq_dm    [0:pcomp_pkg::DIV_BITS];
  logic               dq_neg   [0:pcomp_pkg::DIV_BITS];
  logic               dq_zero  [0:pcomp_pkg::DIV_BITS];
  logic signed [15:0] dq_centi [0:pcomp_pkg::DIV_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      dq_rem[0]   <= '0;
      dq_num[0]   <= s12_n[63] ? (64'd0 - s12_n) : s12_n;
      dq_dm[0]    <= s12_dm;
      dq_neg[0]   <= s12_n[63] ^ s12_dneg;
      dq_zero[0]  <= s12_zero;
      dq_centi[0] <= s12_centi;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= pcomp_pkg::DIV_BITS; k++) begin
        logic [31:0] trial;
        logic        ge;
        trial = {dq_rem[k-1], dq_num[k-1][63]};
        ge    = trial >= {1'b0, dq_dm[k-1]};
        dq_rem[k]   <= ge ? 31'(trial - {1'b0, dq_dm[k-1]}) : trial[30:0];
        dq_num[k]   <= {dq_num[k-1][62:0], ge};
        dq_dm[k]    <= dq_dm[k-1];
        dq_neg[k]   <= dq_neg[k-1];
        dq_zero[k]  <= dq_zero[k-1];
        dq_centi[k] <= dq_centi[k-1];
      end
    end
  end

  // stage 14: signed quotient
  logic [63:0]        s14_p;
  logic               s14_zero;
  logic signed [15:0] s14_centi;
  always_ff @(posedge clk) begin
    if (en) begin
      s14_p     <= dq_neg[pcomp_pkg::DIV_BITS] ? (64'd0 - dq_num[pcomp_pkg::DIV_BITS])
                                               : dq_num[pcomp_pkg::DIV_BITS];
      s14_zero  <= dq_zero[pcomp_pkg::DIV_BITS];
      s14_centi <= dq_centi[pcomp_pkg::DIV_BITS];
    end
  end

  // stage 15: partial products of the correction terms
  logic [63:0]        p_s13;
  pcomp_pkg::pp_t     s15_pp9, s15_pp8;
  logic [63:0]        s15_s, s15_p;
  logic               s15_zero;
  logic signed [15:0] s15_centi;
  assign p_s13 = {{13{s14_p[63]}}, s14_p[63:13]};
  always_ff @(posedge clk) begin
    if (en) begin
      s15_pp9   <= pcomp_pkg::pp_mul({{48{p9[15]}}, p9}, p_s13);
      s15_pp8   <= pcomp_pkg::pp_mul({{48{p8[15]}}, p8}, s14_p);
      s15_s     <= p_s13;
      s15_p     <= s14_p;
      s15_zero  <= s14_zero;
      s15_centi <= s14_centi;
    end
  end

  // stage 16: combine
  logic [63:0]        s16_t9, s16_t8, s16_s, s16_p;
  logic               s16_zero;
  logic signed [15:0] s16_centi;
  always_ff @(posedge clk) begin
    if (en) begin
      s16_t9    <= pcomp_pkg::pp_sum(s15_pp9);
      s16_t8    <= pcomp_pkg::pp_sum(s15_pp8);
      s16_s     <= s15_s;
      s16_p     <= s15_p;
      s16_zero  <= s15_zero;
      s16_centi <= s15_centi;
    end
  end

  // stage 17: second factor of the square term
  pcomp_pkg::pp_t     s17_pp;
  logic [63:0]        s17_t8, s17_p;
  logic               s17_zero;
  logic signed [15:0] s17_centi;
  always_ff @(posedge clk) begin
    if (en) begin
      s17_pp    <= pcomp_pkg::pp_mul(s16_t9, s16_s);
      s17_t8    <= s16_t8;
      s17_p     <= s16_p;
      s17_zero  <= s16_zero;
      s17_centi <= s16_centi;
    end
  end

  // stage 18: sum of corrections
  logic [63:0]        t9sq;
  logic [63:0]        s18_sum;
  logic               s18_zero;
  logic signed [15:0] s18_centi;
  assign t9sq = pcomp_pkg::pp_sum(s17_pp);
  always_ff @(posedge clk) begin
    if (en) begin
      s18_sum   <= s17_p + {{25{t9sq[63]}}, t9sq[63:25]} + {{19{s17_t8[63]}}, s17_t8[63:19]};
      s18_zero  <= s17_zero;
      s18_centi <= s17_centi;
    end
  end

  // output stage: final offset, status and saturation
  logic [63:0]        pf;
  logic [31:0]        press_n;
  logic [1:0]         stat_n;
  assign pf = {{8{s18_sum[63]}}, s18_sum[63:8]} + ({{48{p7[15]}}, p7} << 4);
  always_comb begin
    if (s18_zero) begin
      stat_n  = pcomp_pkg::ST_ZERO_DIV;
      press_n = '0;
    end else if (pf[63] || pf == 64'd0) begin
      stat_n  = pcomp_pkg::ST_NON_POS;
      press_n = '0;
    end else begin
      stat_n  = pcomp_pkg::ST_OK;
      press_n = (pf[63:32] != 32'd0) ? 32'hffff_ffff : pf[31:0];
    end
  end

  logic signed [15:0] o_centi, skid_centi;
  logic [31:0]        o_press, skid_press;
  logic [1:0]         o_status, skid_status;

  always_ff @(posedge clk) begin
    if (en) begin
      o_centi  <= s18_centi;
      o_press  <= press_n;
      o_status <= stat_n;
    end
  end

  // skid buffer catches a stalled result while the pipe advances
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_v <= 1'b0;
    end else if (en && o_v && out_stall) begin
      skid_v <= 1'b1;
    end else if (skid_v && !out_stall) begin
      skid_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && o_v && out_stall) begin
      skid_centi  <= o_centi;
      skid_press  <= o_press;
      skid_status <= o_status;
    end
  end

  assign out_valid         = skid_v || o_v;
  assign temperature_centi = skid_v ? skid_centi : o_centi;
  assign pressure_q24_8    = skid_v ? skid_press : o_press;
  assign status            = skid_v ? skid_status : o_status;

  // checks
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == pcomp_pkg::ST_OK || status == pcomp_pkg::ST_ZERO_DIV ||
                   status == pcomp_pkg::ST_NON_POS))
    else $error("reserved status code on output");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != pcomp_pkg::ST_OK) |-> (pressure_q24_8 == 32'd0))
    else $error("error status with nonzero pressure");

  a_skid_catch: assert property (@(posedge clk) disable iff (rst)
    (!skid_v && o_v && out_stall) |=> skid_v)
    else $error("stalled result not saved in skid buffer");

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule
`default_nettype wire

// ----- tb/sv/tb_pressure_temperature_compensation_unit.sv -----
// testbench for the pressure and temperature compensation unit
`default_nettype none
module tb_pressure_temperature_compensation_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] centi;
    logic [31:0]        press;
    logic [1:0]         stat;
  } reading_t;

  // calibration copy and compensation predictor
  class compensation_board;
    logic [47:0] tco;
    logic [63:0] pca, pcb;
    logic [15:0] p9r;
    reading_t    pending[$];
    int          mismatches;

    function void set_reg(logic [1:0] idx, logic [63:0] val);
      case (idx)
        pcomp_pkg::CFG_TEMP: begin
          tco = val[47:0];
        end
        pcomp_pkg::CFG_PRESS_A: begin
          pca = val;
        end
        pcomp_pkg::CFG_PRESS_B: begin
          pcb = val;
        end
        default: begin
          p9r = val[15:0];
        end
      endcase
    endfunction

    function reading_t compensate(logic [19:0] rp, logic [19:0] rt);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] a, b, d, fine, p, c;
      reading_t r;
      t1 = {48'd0, tco[15:0]};
      t2 = {{48{tco[31]}}, tco[31:16]};
      t3 = {{48{tco[47]}}, tco[47:32]};
      p1 = {48'd0, pca[15:0]};
      p2 = {{48{pca[31]}}, pca[31:16]};
      p3 = {{48{pca[47]}}, pca[47:32]};
      p4 = {{48{pca[63]}}, pca[63:48]};
      p5 = {{48{pcb[15]}}, pcb[15:0]};
      p6 = {{48{pcb[31]}}, pcb[31:16]};
      p7 = {{48{pcb[47]}}, pcb[47:32]};
      p8 = {{48{pcb[63]}}, pcb[63:48]};
      p9 = {{48{p9r[15]}}, p9r};
      r = '0;
      // temperature and fine value
      a = (($signed(64'(rt >> 3)) - (t1 <<< 1)) * t2) >>> 11;
      d = $signed(64'(rt >> 4)) - t1;
      b = (((d * d) >>> 12) * t3) >>> 14;
      fine = a + b;
      c = (fine * 5 + 128) >>> 8;
      if (c > 32767) r.centi = 16'sh7fff;
      else if (c < -32768) r.centi = 16'sh8000;
      else r.centi = c[15:0];
      // pressure
      a = fine - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
        r.stat = pcomp_pkg::ST_ZERO_DIV;
      end else begin
        p = 64'sd1048576 - $signed(64'(rp));
        p = (((p <<< 31) - b) * 3125) / a;
        b = (((p9 * (p >>> 13)) * (p >>> 13))) >>> 25;
        d = (p8 * p) >>> 19;
        p = ((p + b + d) >>> 8) + (p7 <<< 4);
        if (p <= 0) r.stat = pcomp_pkg::ST_NON_POS;
        else begin
          r.stat = pcomp_pkg::ST_OK;
          r.press = (p > 64'sh0ffffffff) ? 32'hffffffff : p[31:0];
        end
      end
      return r;
    endfunction

    function void note_request(logic [19:0] rp, logic [19:0] rt);
      pending.push_back(compensate(rp, rt));
    endfunction

    function void check_result(reading_t got);
      reading_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.centi !== want.centi || got.press !== want.press || got.stat !== want.stat) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp t=%0d p=%h s=%0d got t=%0d p=%h s=%0d", want.centi,
                   want.press, want.stat, got.centi, got.press, got.stat);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_write = 0;
  logic [1:0] cfg_index = pcomp_pkg::CFG_TEMP;
  logic [63:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic [19:0] raw_pressure = '0, raw_temperature = '0;
  wire in_stall, out_valid;
  wire signed [15:0] temperature_centi;
  wire [31:0] pressure_q24_8;
  wire [1:0] status;

  compensation_board board = new();
  int unsigned cycles = 0;
  int stall_mode = 0;

  always #1 clk = ~clk;

  pressure_temperature_compensation_unit i_dut (.*);

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall)
      board.check_result({temperature_centi, pressure_q24_8, status});
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
    if ($urandom_range(0, 60) == 0) stall_mode <= $urandom_range(0, 2);
    if (cycles > 600000) begin
      $display("pressure_temperature_compensation_unit test failed");
      $finish;
    end
  end

  // one register write; the caller drops the write enable after the last one
  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic send_request(logic [19:0] rp, logic [19:0] rt);
    in_valid <= 1'b1;
    raw_pressure <= rp;
    raw_temperature <= rt;
    do @(posedge clk); while (in_stall);
    board.note_request(rp, rt);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // typical values, two corner sets, or random ones, sometimes near typical
  task automatic load_calibration(int kind);
    logic [63:0] tc, pa, pb, p9;
    if (kind == 0) begin
      tc = {16'd50, 16'd26435, 16'd27504};
      pa = {16'd2855, 16'h8000 | 16'(-16'sd2588), 16'(-16'sd10685), 16'd36477};
      pb = {16'(-16'sd7), 16'd15500, 16'(-16'sd7), 16'd140};
      pa[47:32] = 16'd3024; pa[31:16] = 16'(-16'sd10685);
      p9 = 64'd6000;
    end else if (kind == 1) begin
      tc = {16'hffff, 16'h7fff, 16'hffff};
      pa = '1; pb = {4{16'h8000}}; p9 = 64'h8000;
    end else if (kind == 2) begin
      tc = '0; pa = '0; pb = '0; p9 = 64'h7fff;
    end else begin
      tc = {$urandom, $urandom};
      pa = {$urandom, $urandom};
      pb = {$urandom, $urandom};
      p9 = {$urandom, $urandom};
      if ($urandom_range(0, 1)) begin
        tc[15:0] = 16'($urandom_range(25000, 30000));
        tc[47:16] = {16'($urandom_range(0, 100)), 16'($urandom_range(20000, 28000))};
        pa[15:0] = 16'($urandom_range(30000, 40000));
      end
    end
    write_reg(pcomp_pkg::CFG_TEMP, tc);
    write_reg(pcomp_pkg::CFG_PRESS_A, pa);
    write_reg(pcomp_pkg::CFG_PRESS_B, pb);
    write_reg(pcomp_pkg::CFG_PRESS_9, p9);
    cfg_write <= 1'b0;
  endtask

  task automatic random_burst(int n);
    int k;
    k = 0;
    while (k < n) begin
      repeat ($urandom_range(1, 20)) begin
        if (k < n) begin
          send_request(20'($urandom_range(0, 20'hfffff)), 20'($urandom_range(0, 20'hfffff)));
          k++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  initial begin
    board.tco = '0; board.pca = '0; board.pcb = '0; board.p9r = '0;
    board.mismatches = 0;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // zero registers: divisor is zero
    send_request(20'd0, 20'd0);
    send_request(20'hfffff, 20'hfffff);
    drain();
    load_calibration(0);
    send_request(20'd0, 20'd0);
    send_request(20'hfffff, 20'hfffff);
    send_request(20'h55555, 20'haaaaa);
    send_request(20'haaaaa, 20'h55555);
    send_request(20'd415148, 20'd519888);
    send_request(20'd1, 20'hfffff);
    drain();
    load_calibration(1);
    send_request(20'd0, 20'hfffff);
    send_request(20'hfffff, 20'd0);
    send_request(20'h80000, 20'h80000);
    drain();
    load_calibration(2);
    send_request(20'd12345, 20'd54321);
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      load_calibration(ph % 4 == 0 ? 0 : 3);
      random_burst(160);
      drain();
    end
    if (board.mismatches == 0 && board.pending.size() == 0)
      $display("pressure_temperature_compensation_unit test passed");
    else
      $display("pressure_temperature_compensation_unit test failed");
    $finish;
  end
endmodule
`default_nettype wire
